### design/ising_ring_spin_update_assert.svh
// Assertion macros for the ring spin update block.
`ifndef ISING_RING_SPIN_UPDATE_ASSERT_SVH
`define ISING_RING_SPIN_UPDATE_ASSERT_SVH
`ifndef SYNTHESIS
`define ISR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("isr assertion failed");
`define ISR_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("isr assertion failed");
`else
`define ISR_ASSERT(lbl, clk, rst_n, prop)
`define ISR_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

### design/isr_pkg.sv
package isr_pkg;

    localparam int MAX_SPINS_DEF = 1024;
    localparam int PROB_BITS_DEF = 16;

    localparam int SITE_W       = 10;
    localparam int UNIF_W       = 16;
    localparam int PROB_W       = 16;
    localparam int TABLE_W      = 48;
    localparam int RES_W        = 12;
    localparam int SPIN_COUNT_W = 11;
    localparam int CFG_IDX_W    = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE_SELECT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPIN_COUNT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_METRO_UP       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_METRO_DOWN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GIBBS_PROP_UP  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GIBBS_PROP_DN  = 3'd5;

    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_WRITE  = 1'b1;
    localparam logic MODE_GIBBS = 1'b0;
    localparam logic MODE_METRO = 1'b1;

    localparam logic                    MODE_RST       = MODE_METRO;
    localparam int                      SPIN_COUNT_RST = 1024;
    localparam logic [TABLE_W-1:0]      METRO_PROB_RST = 48'hFFFF_FFFF_FFFF;
    localparam logic [TABLE_W-1:0]      GIBBS_PROB_RST = 48'h8000_8000_8000;

    typedef struct packed {
        logic               mode;
        logic [TABLE_W-1:0] metro_up;
        logic [TABLE_W-1:0] metro_dn;
        logic [TABLE_W-1:0] gibbs_up;
        logic [TABLE_W-1:0] gibbs_dn;
    } t_cfg;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ_RIGHT,
        S_UPDATE,
        S_SWEEP,
        S_SWEEP_END
    } t_state;

endpackage

### design/isr_item_if.sv
interface isr_item_if;
    import isr_pkg::*;

    logic              valid;
    logic              ready;
    logic              command;
    logic [SITE_W-1:0] site;
    logic              spin_value;
    logic              proposal_up;
    logic [UNIF_W-1:0] uniform;

    modport source (output valid, command, site, spin_value, proposal_up, uniform,
                    input ready);
    modport sink   (input valid, command, site, spin_value, proposal_up, uniform,
                    output ready);
endinterface

### design/isr_result_if.sv
interface isr_result_if;
    import isr_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    new_spin;
    logic                    changed;
    logic signed [RES_W-1:0] magnetization;
    logic signed [RES_W-1:0] bond_sum;

    modport source (output valid, new_spin, changed, magnetization, bond_sum,
                    input ready);
    modport sink   (input valid, new_spin, changed, magnetization, bond_sum,
                    output ready);
endinterface

### design/isr_cfg_if.sv
interface isr_cfg_if;
    import isr_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [TABLE_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### design/isr_spin_mem.sv
module isr_spin_mem #(
    parameter int DEPTH = isr_pkg::MAX_SPINS_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_re_a,
    input  logic [AW-1:0] i_addr_a,
    output logic          o_data_a,
    input  logic          i_re_b,
    input  logic [AW-1:0] i_addr_b,
    output logic          o_data_b,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic          i_wdata
);
    logic r_mem [DEPTH];
    logic r_data_a;
    logic r_data_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds while the port is idle
    always_ff @(posedge i_clk) begin
        if (i_re_a) begin
            r_data_a <= r_mem[i_addr_a];
        end
        if (i_re_b) begin
            r_data_b <= r_mem[i_addr_b];
        end
    end

    assign o_data_a = r_data_a;
    assign o_data_b = r_data_b;
endmodule

### design/isr_cfg_regs.sv
module isr_cfg_regs #(
    parameter int MAX_SPINS = isr_pkg::MAX_SPINS_DEF,
    localparam int CW = $clog2(MAX_SPINS + 1),
    localparam int LW = (CW > isr_pkg::SPIN_COUNT_W) ? CW : isr_pkg::SPIN_COUNT_W
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_wr_en,
    input  logic [isr_pkg::CFG_IDX_W-1:0]  i_index,
    input  logic [isr_pkg::TABLE_W-1:0]    i_data,
    output isr_pkg::t_cfg                  o_cfg,
    output logic [LW-1:0]                  o_len
);
    import isr_pkg::*;

    localparam int LEN_RST = (SPIN_COUNT_RST > MAX_SPINS) ? MAX_SPINS : SPIN_COUNT_RST;

    t_cfg          r_cfg;
    logic [LW-1:0] r_len;
    logic [LW-1:0] wr_count;
    logic [LW-1:0] wr_len;

    // ring length is clamped once, at write time
    always_comb begin
        wr_count = LW'(i_data[SPIN_COUNT_W-1:0]);
        if (wr_count < LW'(2)) begin
            wr_len = LW'(2);
        end else if (wr_count > LW'(MAX_SPINS)) begin
            wr_len = LW'(MAX_SPINS);
        end else begin
            wr_len = wr_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode     <= MODE_RST;
            r_cfg.metro_up <= METRO_PROB_RST;
            r_cfg.metro_dn <= METRO_PROB_RST;
            r_cfg.gibbs_up <= GIBBS_PROB_RST;
            r_cfg.gibbs_dn <= GIBBS_PROB_RST;
            r_len          <= LW'(LEN_RST);
        end else if (i_wr_en) begin
            unique case (i_index)
                REG_MODE_SELECT:   r_cfg.mode     <= i_data[0];
                REG_SPIN_COUNT:    r_len          <= wr_len;
                REG_METRO_UP:      r_cfg.metro_up <= i_data;
                REG_METRO_DOWN:    r_cfg.metro_dn <= i_data;
                REG_GIBBS_PROP_UP: r_cfg.gibbs_up <= i_data;
                REG_GIBBS_PROP_DN: r_cfg.gibbs_dn <= i_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;
    assign o_len = r_len;
endmodule

### design/isr_decide.sv
module isr_decide #(
    parameter int PROB_BITS = isr_pkg::PROB_BITS_DEF
) (
    input  isr_pkg::t_cfg                 i_cfg,
    input  logic                          i_command,
    input  logic                          i_spin_value,
    input  logic                          i_proposal_up,
    input  logic [isr_pkg::UNIF_W-1:0]    i_uniform,
    input  logic                          i_old,
    input  logic                          i_left,
    input  logic                          i_right,
    output logic                          o_new_spin
);
    import isr_pkg::*;

    logic [TABLE_W-1:0]   prob_table;
    logic [PROB_W-1:0]    word;
    logic [PROB_BITS-1:0] p_kept;
    logic [PROB_BITS-1:0] u_kept;
    logic                 accept;

    always_comb begin
        if (i_cfg.mode == MODE_METRO) begin
            prob_table = i_old ? i_cfg.metro_up : i_cfg.metro_dn;
        end else begin
            prob_table = i_proposal_up ? i_cfg.gibbs_up : i_cfg.gibbs_dn;
        end

        // neighbour sum -2, 0, +2 picks the low, middle or high word
        unique case ({i_left, i_right})
            2'b00:   word = prob_table[PROB_W-1:0];
            2'b11:   word = prob_table[3*PROB_W-1:2*PROB_W];
            default: word = prob_table[2*PROB_W-1:PROB_W];
        endcase

        p_kept = word[PROB_W-1 -: PROB_BITS];
        u_kept = i_uniform[UNIF_W-1 -: PROB_BITS];
        accept = (&p_kept) || (u_kept < p_kept);

        if (i_command == CMD_WRITE) begin
            o_new_spin = i_spin_value;
        end else if (i_cfg.mode == MODE_METRO) begin
            o_new_spin = accept ? !i_old : i_old;
        end else begin
            o_new_spin = accept ? i_proposal_up : !i_proposal_up;
        end
    end
endmodule

### design/ising_ring_spin_update.sv
// Ring of one-bit spins with periodic neighbours, one site visited per item.
// Channels: i_item takes update or spin-write commands, o_result returns one
// result per item (new spin, changed flag, magnetization, bond sum), and i_cfg
// writes the mode, ring length and the four probability tables by index.
// Each item passes through the states in order: the accept edge reads the site
// and its left neighbour, S_READ_RIGHT reads the right neighbour, and S_UPDATE
// writes back the spin and loads the result register once the output register
// is free, so a new item is taken only after the last has left S_UPDATE. The
// spin memory ports (two reads, one write) set this schedule.
// After reset the block sweeps the spin memory to all up, one entry per
// cycle; i_item.ready stays low meanwhile while i_cfg still takes writes.
// Writing spin_count outside that sweep recounts the down spins and walls
// over the new ring, with both i_item and i_cfg held off.
// A result waiting on a stalled receiver sits in the output register; the next
// item is still accepted and waits before write-back until that slot frees.
`include "ising_ring_spin_update_assert.svh"

module ising_ring_spin_update #(
    parameter int MAX_SPINS = isr_pkg::MAX_SPINS_DEF,
    parameter int PROB_BITS = isr_pkg::PROB_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    isr_item_if.sink        i_item,
    isr_result_if.source    o_result,
    isr_cfg_if.sink         i_cfg
);
    import isr_pkg::*;

    localparam int AW = $clog2(MAX_SPINS);
    localparam int CW = $clog2(MAX_SPINS + 1);
    localparam int LW = (CW > SPIN_COUNT_W) ? CW : SPIN_COUNT_W;

    t_state r_state;
    t_state n_state;

    t_cfg          cfg;
    logic [LW-1:0] len;
    logic          cfg_ready;
    logic          cfg_wr;
    logic          len_wr;
    logic          item_ready;
    logic          item_acc;

    // memory controls
    logic          mem_re_a;
    logic [AW-1:0] mem_addr_a;
    logic          mem_data_a;
    logic          mem_re_b;
    logic [AW-1:0] mem_addr_b;
    logic          mem_data_b;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic          mem_wdata;

    // site decode at accept
    logic [LW-1:0] site_l;
    logic [LW-1:0] left_l;
    logic [LW-1:0] right_l;

    // sweep index and counters
    logic [AW-1:0] r_idx;
    logic          r_acc_vld;
    logic [CW-1:0] r_down;
    logic [CW-1:0] r_wall;
    logic          sweep_last;
    logic [AW-1:0] sweep_next;
    logic          clear_last;

    // item held across the three steps
    logic [AW-1:0]     r_site;
    logic [AW-1:0]     r_right;
    logic              r_in_ring;
    logic              r_in_mem;
    logic              r_cmd;
    logic              r_wval;
    logic              r_prop;
    logic [UNIF_W-1:0] r_unif;
    logic              r_sl;

    logic          nv;
    logic          chg;
    logic          advance;
    logic [1:0]    eq_cnt;
    logic [CW-1:0] down_upd;
    logic [CW-1:0] wall_upd;
    logic [CW-1:0] n_down_x;
    logic [CW-1:0] n_wall_x;
    logic [LW:0]   mag_full;
    logic [LW:0]   bond_full;
    logic          res_spin;

    logic             r_out_valid;
    logic             r_res_spin;
    logic             r_res_chg;
    logic [RES_W-1:0] r_res_mag;
    logic [RES_W-1:0] r_res_bond;

    isr_cfg_regs #(
        .MAX_SPINS (MAX_SPINS)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (cfg_wr),
        .i_index (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_cfg   (cfg),
        .o_len   (len)
    );

    isr_spin_mem #(
        .DEPTH (MAX_SPINS)
    ) u_mem (
        .i_clk    (i_clk),
        .i_re_a   (mem_re_a),
        .i_addr_a (mem_addr_a),
        .o_data_a (mem_data_a),
        .i_re_b   (mem_re_b),
        .i_addr_b (mem_addr_b),
        .o_data_b (mem_data_b),
        .i_we     (mem_we),
        .i_waddr  (mem_waddr),
        .i_wdata  (mem_wdata)
    );

    isr_decide #(
        .PROB_BITS (PROB_BITS)
    ) u_decide (
        .i_cfg         (cfg),
        .i_command     (r_cmd),
        .i_spin_value  (r_wval),
        .i_proposal_up (r_prop),
        .i_uniform     (r_unif),
        .i_old         (mem_data_a),
        .i_left        (r_sl),
        .i_right       (mem_data_b),
        .o_new_spin    (nv)
    );

    assign item_acc = i_item.valid && item_ready;
    assign cfg_wr   = i_cfg.valid && cfg_ready;
    assign len_wr   = cfg_wr && (i_cfg.index == REG_SPIN_COUNT);

    always_comb begin
        site_l  = LW'(i_item.site);
        left_l  = (site_l == '0) ? len - LW'(1) : site_l - LW'(1);
        right_l = ((site_l + LW'(1)) == len) ? '0 : site_l + LW'(1);
    end

    assign sweep_last = (LW'(r_idx) + LW'(1)) == len;
    assign sweep_next = sweep_last ? '0 : r_idx + AW'(1);
    assign clear_last = r_idx == AW'(MAX_SPINS - 1);

    // write-back datapath; mem_data_a is the old spin, mem_data_b the right one
    always_comb begin
        chg       = r_in_ring && (nv != mem_data_a);
        advance   = !r_out_valid || o_result.ready;
        eq_cnt    = {1'b0, mem_data_a == r_sl} + {1'b0, mem_data_a == mem_data_b};
        down_upd  = nv ? r_down - CW'(1) : r_down + CW'(1);
        // each neighbour equal to the old spin becomes a wall, else one goes away
        wall_upd  = r_wall + CW'({eq_cnt, 1'b0}) - CW'(2);
        n_down_x  = chg ? down_upd : r_down;
        n_wall_x  = chg ? wall_upd : r_wall;
        mag_full  = {1'b0, len} - {LW'(n_down_x), 1'b0};
        bond_full = {1'b0, len} - {LW'(n_wall_x), 1'b0};
        if (r_in_ring) begin
            res_spin = nv;
        end else begin
            res_spin = r_in_mem && mem_data_a;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (item_acc) begin
                    n_state = S_READ_RIGHT;
                end else if (len_wr) begin
                    n_state = S_SWEEP;
                end
            end
            S_READ_RIGHT: n_state = S_UPDATE;
            S_UPDATE: begin
                if (advance) n_state = S_IDLE;
            end
            S_SWEEP: begin
                if (sweep_last) n_state = S_SWEEP_END;
            end
            S_SWEEP_END: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        item_ready = 1'b0;
        cfg_ready  = 1'b0;
        mem_re_a   = 1'b0;
        mem_addr_a = r_idx;
        mem_re_b   = 1'b0;
        mem_addr_b = r_right;
        mem_we     = 1'b0;
        mem_waddr  = r_site;
        mem_wdata  = nv;
        unique case (r_state)
            S_CLEAR: begin
                cfg_ready = 1'b1;
                mem_we    = 1'b1;
                mem_waddr = r_idx;
                mem_wdata = 1'b1;
            end
            S_IDLE: begin
                item_ready = 1'b1;
                cfg_ready  = !i_item.valid;
                mem_re_a   = i_item.valid;
                mem_addr_a = site_l[AW-1:0];
                mem_re_b   = i_item.valid;
                mem_addr_b = left_l[AW-1:0];
            end
            S_READ_RIGHT: begin
                mem_re_b = 1'b1;
            end
            S_UPDATE: begin
                mem_we = advance && chg;
            end
            S_SWEEP: begin
                mem_re_a   = 1'b1;
                mem_re_b   = 1'b1;
                mem_addr_b = sweep_next;
            end
            S_SWEEP_END: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_acc_vld   <= 1'b0;
            r_down      <= '0;
            r_wall      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_acc_vld <= (r_state == S_SWEEP);

            if (r_state == S_IDLE && n_state == S_SWEEP) begin
                r_idx <= '0;
            end else if (r_state == S_CLEAR || r_state == S_SWEEP) begin
                r_idx <= r_idx + AW'(1);
            end

            priority if (r_state == S_IDLE && n_state == S_SWEEP) begin
                r_down <= '0;
                r_wall <= '0;
            end else if (r_acc_vld) begin
                r_down <= r_down + CW'(!mem_data_a);
                r_wall <= r_wall + CW'(mem_data_a ^ mem_data_b);
            end else if (r_state == S_UPDATE && advance) begin
                r_down <= n_down_x;
                r_wall <= n_wall_x;
            end

            if (r_state == S_UPDATE && advance) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (item_acc) begin
            r_site    <= site_l[AW-1:0];
            r_right   <= right_l[AW-1:0];
            r_in_ring <= site_l < len;
            r_in_mem  <= site_l < LW'(MAX_SPINS);
            r_cmd     <= i_item.command;
            r_wval    <= i_item.spin_value;
            r_prop    <= i_item.proposal_up;
            r_unif    <= i_item.uniform;
        end
        if (r_state == S_READ_RIGHT) begin
            r_sl <= mem_data_b;
        end
        if (r_state == S_UPDATE && advance) begin
            r_res_spin <= res_spin;
            r_res_chg  <= chg;
            r_res_mag  <= mag_full[RES_W-1:0];
            r_res_bond <= bond_full[RES_W-1:0];
        end
    end

    assign i_item.ready           = item_ready;
    assign i_cfg.ready            = cfg_ready;
    assign o_result.valid         = r_out_valid;
    assign o_result.new_spin      = r_res_spin;
    assign o_result.changed       = r_res_chg;
    assign o_result.magnetization = $signed(r_res_mag);
    assign o_result.bond_sum      = $signed(r_res_bond);

    // a closed ring always has an even number of walls
    `ISR_ASSERT(a_wall_even, i_clk, i_rst_n, (r_state == S_IDLE) |-> !r_wall[0])
    `ISR_ASSERT(a_down_bound, i_clk, i_rst_n, (r_state == S_IDLE) |-> (LW'(r_down) <= len))
    `ISR_ASSERT(a_write_owner, i_clk, i_rst_n, mem_we |-> ((r_state == S_CLEAR) || (r_state == S_UPDATE)))
    `ISR_ASSERT(a_result_src, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_state == S_UPDATE))
    `ISR_ASSERT_ALWAYS(a_no_dual_accept, i_clk, !(item_acc && cfg_wr))
endmodule
